// ===== rtl/core/ppsfde_pkg.sv =====
// Shared types, widths and constants of the PPS frequency deviation estimator.
package ppsfde_pkg;

  localparam int PPS_DEFAULT          = 8;
  localparam int CAPTURE_BITS_DEFAULT = 24;

  localparam int COUNT_W    = 8;
  localparam int CAPFIELD_W = 24;
  localparam int DEV_W      = 32;
  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int TERM_W     = 26;
  localparam int SECREF_W   = 40;
  localparam int RF_W       = 32;

  localparam logic [COUNT_W-1:0] MAX_COUNT       = 8'd255;
  localparam logic [COUNT_W-1:0] END_COUNT_MULTI = 8'd7;
  localparam logic [COUNT_W-1:0] END_COUNT_RESET = 8'd7;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SECONDS,
    CFG_MODE,
    CFG_END_COUNT,
    CFG_CAPTURE_BIAS,
    CFG_WRAP_THRESHOLD,
    CFG_WRAP_ADD,
    CFG_REF_CLK,
    CFG_RF_HZ
  } cfg_index_t;

  typedef enum logic [1:0] {
    EV_NONE,
    EV_END,
    EV_ABORT
  } event_t;

  typedef enum logic [2:0] {
    ENG_IDLE,
    ENG_SUM,
    ENG_PREP,
    ENG_MUL,
    ENG_DIV,
    ENG_DONE
  } eng_state_t;

endpackage

// ===== rtl/core/ppsfde_engine.sv =====
// Bit-serial multiply and restoring divide that turns a window offset into a deviation.
module ppsfde_engine import ppsfde_pkg::*; #(
  parameter int SUM_W = 37
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [SUM_W-1:0] start_sum,
  input  logic [SECREF_W-1:0]     secref,
  input  logic [RF_W-1:0]         rf_hz,
  output logic                    busy,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [DEV_W-1:0] out_deviation
);

  localparam int DIV_W  = ((SUM_W > SECREF_W) ? SUM_W : SECREF_W) + 2;
  localparam int MAG_W  = SUM_W - 1;
  localparam int DMAG_W = DIV_W - 1;
  localparam int NUM_W  = MAG_W + RF_W;
  localparam int CNT_W  = $clog2(NUM_W);

  eng_state_t               state_r, state_nxt;
  logic signed [SUM_W-1:0]  sum_r, sum_nxt;
  logic signed [DIV_W-1:0]  div_r, div_nxt;
  logic                     neg_r, neg_nxt;
  logic [MAG_W-1:0]         mag_r, mag_nxt;
  logic [DMAG_W-1:0]        dmag_r, dmag_nxt;
  logic [NUM_W-1:0]         prod_r, prod_nxt;
  logic [DMAG_W-1:0]        rem_r, rem_nxt;
  logic [DEV_W-1:0]         quo_r, quo_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [DEV_W-1:0]  out_dev_r, out_dev_nxt;

  logic [MAG_W:0]           psum;
  logic [DMAG_W:0]          trial;
  logic [DMAG_W:0]          diff;
  logic                     ge;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ENG_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_r     <= sum_nxt;
    div_r     <= div_nxt;
    neg_r     <= neg_nxt;
    mag_r     <= mag_nxt;
    dmag_r    <= dmag_nxt;
    prod_r    <= prod_nxt;
    rem_r     <= rem_nxt;
    quo_r     <= quo_nxt;
    cnt_r     <= cnt_nxt;
    out_dev_r <= out_dev_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    sum_nxt       = sum_r;
    div_nxt       = div_r;
    neg_nxt       = neg_r;
    mag_nxt       = mag_r;
    dmag_nxt      = dmag_r;
    prod_nxt      = prod_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    cnt_nxt       = cnt_r;
    out_dev_nxt   = out_dev_r;
    out_valid_nxt = out_valid_r && !out_ready;

    psum  = {1'b0, prod_r[NUM_W-1:RF_W]} + (prod_r[0] ? {1'b0, mag_r} : {(MAG_W+1){1'b0}});
    trial = {rem_r, prod_r[NUM_W-1]};
    diff  = trial - {1'b0, dmag_r};
    ge    = (trial >= {1'b0, dmag_r});

    case (state_r)
      ENG_IDLE: begin
        if (start) begin
          sum_nxt   = start_sum;
          state_nxt = ENG_SUM;
        end
      end
      ENG_SUM: begin
        div_nxt   = $signed(DIV_W'(secref)) + DIV_W'(sum_r);
        state_nxt = ENG_PREP;
      end
      ENG_PREP: begin
        if (div_r == '0) begin
          state_nxt = ENG_IDLE;
        end else begin
          neg_nxt   = (sum_r > 0) != div_r[DIV_W-1];
          mag_nxt   = sum_r[SUM_W-1] ? MAG_W'(-sum_r) : MAG_W'(sum_r);
          dmag_nxt  = div_r[DIV_W-1] ? DMAG_W'(-div_r) : DMAG_W'(div_r);
          prod_nxt  = NUM_W'(rf_hz);
          rem_nxt   = '0;
          cnt_nxt   = CNT_W'(RF_W - 1);
          state_nxt = ENG_MUL;
        end
      end
      ENG_MUL: begin
        prod_nxt = {psum, prod_r[RF_W-1:1]};
        if (cnt_r == '0) begin
          cnt_nxt   = CNT_W'(NUM_W - 1);
          state_nxt = ENG_DIV;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ENG_DIV: begin
        rem_nxt  = ge ? diff[DMAG_W-1:0] : trial[DMAG_W-1:0];
        prod_nxt = {prod_r[NUM_W-2:0], 1'b0};
        quo_nxt  = {quo_r[DEV_W-2:0], ge};
        if (cnt_r == '0) begin
          state_nxt = ENG_DONE;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ENG_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_dev_nxt   = neg_r ? $signed(DEV_W'(-quo_r)) : $signed(quo_r);
          out_valid_nxt = 1'b1;
          state_nxt     = ENG_IDLE;
        end
      end
      default: begin
        state_nxt = ENG_IDLE;
      end
    endcase
  end

  assign busy          = (state_r != ENG_IDLE);
  assign out_valid     = out_valid_r;
  assign out_deviation = out_dev_r;

endmodule

// ===== rtl/core/pps_frequency_deviation_estimator_top.sv =====
// Top level of the PPS frequency deviation estimator.
//
// The input channel carries one polled sample per transaction: the millisecond
// timer count and the PPS capture read with it. The result channel carries a
// signed deviation in hertz, produced only when an estimation window closes
// with a nonzero divisor. Registers are written through the cfg port at any
// edge where cfg_we is high; they are meant to change only while idle.
//
// A sample that does not close a window leaves in_ready high, and the next
// sample may follow in the next cycle. A sample that closes a window starts the
// arithmetic engine: it captures the window sum, forms the divisor, sets up,
// runs a shift-add multiply by rf_hz and then a restoring division over NUM_W
// product bits, where NUM_W is the offset magnitude width plus 32 (68 at
// default parameters), and finally loads the output register. The next sample
// can be accepted once the result is loaded. A zero divisor returns the engine
// to idle from its setup step with no result. The input is held off while the
// engine runs, and the engine holds its result while the output register is
// still occupied by an unclaimed transaction. Reset clears the window, the
// sample history, all configuration registers and the output valid flag.
module pps_frequency_deviation_estimator_top import ppsfde_pkg::*; #(
  parameter int PULSES_PER_SECOND = PPS_DEFAULT,
  parameter int CAPTURE_BITS      = CAPTURE_BITS_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [COUNT_W-1:0]      in_timer_count,
  input  logic [CAPFIELD_W-1:0]   in_capture_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [DEV_W-1:0] out_deviation,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]        cfg_wdata
);

  localparam int CAP_W      = (CAPTURE_BITS < CAPFIELD_W) ? CAPTURE_BITS : CAPFIELD_W;
  localparam int MAX_PULSES = int'(MAX_COUNT) * PULSES_PER_SECOND;
  localparam int PIDX_W     = $clog2(MAX_PULSES + 1);
  localparam int SUM_W      = PIDX_W + TERM_W;

  logic [7:0]               seconds_r;
  logic                     mode_r;
  logic [COUNT_W-1:0]       end_count_r;
  logic [CAPFIELD_W-1:0]    capture_bias_r;
  logic [CAPFIELD_W-1:0]    wrap_threshold_r;
  logic [CAPFIELD_W-1:0]    wrap_add_r;
  logic [31:0]              ref_clk_r;
  logic [RF_W-1:0]          rf_hz_r;
  logic [SECREF_W-1:0]      secref_r;

  logic [COUNT_W-1:0]       prev_count_r, prev_count_nxt;
  logic                     have_prev_r, have_prev_nxt;
  logic [PIDX_W-1:0]        pidx_r, pidx_nxt;
  logic signed [SUM_W-1:0]  sum_r, sum_nxt;

  logic                     accept;
  logic                     start;
  logic                     eng_busy;
  logic [CAPFIELD_W-1:0]    cap;
  logic [COUNT_W-1:0]       end_mark;
  logic [COUNT_W:0]         end_plus;
  logic                     wrapped;
  logic signed [TERM_W-1:0] term;
  logic signed [SUM_W-1:0]  sum_add;
  logic [PIDX_W-1:0]        pidx_inc;
  logic [PIDX_W-1:0]        need;
  event_t                   ev;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seconds_r        <= '0;
      mode_r           <= 1'b0;
      end_count_r      <= END_COUNT_RESET;
      capture_bias_r   <= '0;
      wrap_threshold_r <= '0;
      wrap_add_r       <= '0;
      ref_clk_r        <= '0;
      rf_hz_r          <= '0;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_SECONDS:        seconds_r        <= cfg_wdata[7:0];
        CFG_MODE:           mode_r           <= cfg_wdata[0];
        CFG_END_COUNT:      end_count_r      <= cfg_wdata[COUNT_W-1:0];
        CFG_CAPTURE_BIAS:   capture_bias_r   <= cfg_wdata[CAPFIELD_W-1:0];
        CFG_WRAP_THRESHOLD: wrap_threshold_r <= cfg_wdata[CAPFIELD_W-1:0];
        CFG_WRAP_ADD:       wrap_add_r       <= cfg_wdata[CAPFIELD_W-1:0];
        CFG_REF_CLK:        ref_clk_r        <= cfg_wdata;
        CFG_RF_HZ:          rf_hz_r          <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    secref_r <= SECREF_W'(seconds_r) * SECREF_W'(ref_clk_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_count_r <= '0;
      have_prev_r  <= 1'b0;
      pidx_r       <= '0;
      sum_r        <= '0;
    end else begin
      prev_count_r <= prev_count_nxt;
      have_prev_r  <= have_prev_nxt;
      pidx_r       <= pidx_nxt;
      sum_r        <= sum_nxt;
    end
  end

  always_comb begin
    cap      = CAPFIELD_W'(in_capture_value[CAP_W-1:0]);
    end_mark = mode_r ? END_COUNT_MULTI : end_count_r;
    end_plus = {1'b0, end_mark} + 1'b1;

    if (in_timer_count == '0) begin
      if (prev_count_r == end_mark) begin
        ev = EV_END;
      end else if (prev_count_r != MAX_COUNT) begin
        ev = EV_ABORT;
      end else begin
        ev = EV_NONE;
      end
    end else if (in_timer_count == COUNT_W'(1)) begin
      ev = (prev_count_r != MAX_COUNT && prev_count_r != '0) ? EV_ABORT : EV_NONE;
    end else if ({1'b0, in_timer_count} > end_plus) begin
      ev = EV_ABORT;
    end else begin
      ev = EV_NONE;
    end

    wrapped = !mode_r && (cap < wrap_threshold_r);
    term    = wrapped ?
              $signed(TERM_W'(cap) + TERM_W'(wrap_add_r) + TERM_W'(1)) :
              $signed(TERM_W'(cap) - TERM_W'(capture_bias_r) + TERM_W'(1));
    sum_add  = sum_r + SUM_W'(term);
    pidx_inc = pidx_r + 1'b1;
    need     = mode_r ? PIDX_W'(int'(seconds_r) * PULSES_PER_SECOND) : PIDX_W'(seconds_r);

    accept         = in_valid && in_ready;
    start          = 1'b0;
    prev_count_nxt = prev_count_r;
    have_prev_nxt  = have_prev_r;
    pidx_nxt       = pidx_r;
    sum_nxt        = sum_r;

    if (accept) begin
      if (seconds_r == '0) begin
        have_prev_nxt = 1'b0;
        pidx_nxt      = '0;
        sum_nxt       = '0;
      end else if (!have_prev_r) begin
        prev_count_nxt = in_timer_count;
        have_prev_nxt  = 1'b1;
      end else if (in_timer_count != prev_count_r) begin
        case (ev)
          EV_NONE: begin
            prev_count_nxt = in_timer_count;
          end
          EV_ABORT: begin
            have_prev_nxt = 1'b0;
            pidx_nxt      = '0;
            sum_nxt       = '0;
          end
          EV_END: begin
            have_prev_nxt = 1'b0;
            if (pidx_inc >= need) begin
              pidx_nxt = '0;
              sum_nxt  = '0;
              start    = 1'b1;
            end else begin
              pidx_nxt = pidx_inc;
              sum_nxt  = sum_add;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign in_ready = !eng_busy;

  ppsfde_engine #(
    .SUM_W (SUM_W)
  ) u_engine (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .start_sum     (sum_add),
    .secref        (secref_r),
    .rf_hz         (rf_hz_r),
    .busy          (eng_busy),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_deviation (out_deviation)
  );

endmodule

// ===== rtl/core/ppsfde_checker.sv =====
// Port-level checker of the PPS frequency deviation estimator and its bind.
module ppsfde_checker import ppsfde_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [DEV_W-1:0] out_deviation
);

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Output valid survived reset.");

  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("Result appeared without a preceding computation.");

  a_busy_needs_input: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_ready) |-> $past(in_valid && in_ready))
    else $error("Input ready dropped without an accepted transaction.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_deviation))
    else $error("Stalled result changed or vanished.");

endmodule

bind pps_frequency_deviation_estimator_top ppsfde_checker u_ppsfde_checker (.*);

// ===== sim/testbench.sv =====
// Self-checking testbench for the PPS frequency deviation estimator.
module testbench;
  import ppsfde_pkg::*;

  localparam int ENGINE_LATENCY = 120;
  localparam int MAX_WAIT       = 11;
  localparam int RANDOM_ITEMS   = 1900;
  localparam int RUN_LIMIT      = 4_000_000;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [COUNT_W-1:0] in_timer_count;
  logic [CAPFIELD_W-1:0] in_capture_value;
  logic out_valid;
  logic out_ready;
  logic signed [DEV_W-1:0] out_deviation;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  // Register shadow used by the deviation predictor.
  logic [7:0] win_seconds;
  logic pps_mode;
  logic [7:0] end_mark;
  logic [23:0] cap_bias;
  logic [23:0] wrap_thr;
  logic [23:0] wrap_add_v;
  logic [31:0] ref_ticks;
  logic [31:0] rf_freq;

  // Window tracking state of the predictor.
  logic [7:0] last_count;
  logic last_valid;
  int pulses_seen;
  longint offset_acc;

  logic signed [DEV_W-1:0] expected_deviation[$];

  int error_count;
  int live_items;
  int stall_left;
  bit no_idle;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  pps_frequency_deviation_estimator_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_timer_count(in_timer_count),
    .in_capture_value(in_capture_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_deviation(out_deviation),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  task report_mismatch(input string what);
    $display("ERROR at %0t: %s", $time, what);
    error_count++;
  endtask

  task clear_window;
    pulses_seen = 0;
    offset_acc = 0;
  endtask

  task predict_sample(input logic [COUNT_W-1:0] cnt, input logic [CAPFIELD_W-1:0] cap);
    logic [7:0] e;
    event_t ev;
    int need;
    longint den;
    logic signed [127:0] num;
    logic signed [127:0] den_w;
    logic signed [127:0] quo;
    e = pps_mode ? END_COUNT_MULTI : end_mark;
    if (win_seconds == 0) begin
      last_valid = 1'b0;
      clear_window();
      return;
    end
    if (!last_valid) begin
      last_count = cnt;
      last_valid = 1'b1;
      return;
    end
    if (cnt == last_count) return;
    ev = EV_NONE;
    if (cnt == 8'd0) begin
      if (last_count == e) ev = EV_END;
      else if (last_count != MAX_COUNT) ev = EV_ABORT;
    end else if (cnt == 8'd1) begin
      if (last_count != MAX_COUNT && last_count != 8'd0) ev = EV_ABORT;
    end else if (int'(cnt) > int'(e) + 1) begin
      ev = EV_ABORT;
    end
    if (ev == EV_NONE) begin
      last_count = cnt;
      return;
    end
    last_valid = 1'b0;
    if (ev == EV_ABORT) begin
      clear_window();
      return;
    end
    if (!pps_mode && cap < wrap_thr)
      offset_acc += longint'(cap) + longint'(wrap_add_v) + 1;
    else
      offset_acc += longint'(cap) - longint'(cap_bias) + 1;
    pulses_seen++;
    need = pps_mode ? int'(win_seconds) * PPS_DEFAULT : int'(win_seconds);
    if (pulses_seen < need) return;
    den = longint'(win_seconds) * longint'(ref_ticks) + offset_acc;
    num = offset_acc;
    num = -(num * $signed({96'd0, rf_freq}));
    den_w = den;
    clear_window();
    if (den == 0) return;
    quo = num / den_w;
    expected_deviation.push_back(quo[31:0]);
  endtask

  task send_sample(input logic [COUNT_W-1:0] cnt, input logic [CAPFIELD_W-1:0] cap);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_timer_count <= cnt;
    in_capture_value <= cap;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (win_seconds != 0) live_items++;
    predict_sample(cnt, cap);
  endtask

  task wait_idle;
    @(negedge clk) in_valid <= 1'b0;
    while (expected_deviation.size() != 0) @(posedge clk);
    repeat (ENGINE_LATENCY) @(posedge clk);
  endtask

  task write_reg(input cfg_index_t idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_SECONDS:        win_seconds = val[7:0];
      CFG_MODE:           pps_mode = val[0];
      CFG_END_COUNT:      end_mark = val[7:0];
      CFG_CAPTURE_BIAS:   cap_bias = val[23:0];
      CFG_WRAP_THRESHOLD: wrap_thr = val[23:0];
      CFG_WRAP_ADD:       wrap_add_v = val[23:0];
      CFG_REF_CLK:        ref_ticks = val;
      CFG_RF_HZ:          rf_freq = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function logic [31:0] pick_value(input int bits);
    logic [31:0] mask;
    mask = (bits >= 32) ? 32'hFFFF_FFFF : (32'd1 << bits) - 32'd1;
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return mask;
      default: return $urandom & mask;
    endcase
  endfunction

  function logic [CAPFIELD_W-1:0] draw_capture();
    case ($urandom_range(0, 3))
      0: return cap_bias + 24'($urandom_range(0, 64)) - 24'd32;
      default: return 24'($urandom);
    endcase
  endfunction

  task send_pulse;
    logic [7:0] e;
    e = pps_mode ? END_COUNT_MULTI : end_mark;
    if (e >= 8'd3 && $urandom_range(0, 3) == 0)
      send_sample(8'($urandom_range(2, e - 1)), draw_capture());
    send_sample(e, draw_capture());
    if ($urandom_range(0, 5) == 0) send_sample(e, draw_capture());
    send_sample(8'd0, draw_capture());
  endtask

  task send_noise;
    logic [7:0] e;
    e = pps_mode ? END_COUNT_MULTI : end_mark;
    case ($urandom_range(0, 4))
      0: send_sample(8'($urandom), draw_capture());
      1: begin
        send_sample(MAX_COUNT, draw_capture());
        send_sample(8'd0, draw_capture());
      end
      2: begin
        send_sample($urandom_range(0, 1) ? MAX_COUNT : 8'd0, draw_capture());
        send_sample(8'd1, draw_capture());
      end
      3: begin
        send_sample(8'($urandom_range(1, 254)), draw_capture());
        send_sample(8'd0, draw_capture());
      end
      default: begin
        if (e < 8'd253) send_sample(8'($urandom_range(e + 2, 255)), draw_capture());
        else send_sample(8'($urandom), draw_capture());
      end
    endcase
  endtask

  task randomize_registers(input logic [7:0] secs, input logic mode_bit);
    logic [31:0] v;
    write_reg(CFG_SECONDS, secs);
    write_reg(CFG_MODE, mode_bit);
    v = pick_value(8);
    if (v[7:0] == 8'hFF) v = 32'd254;
    write_reg(CFG_END_COUNT, v);
    write_reg(CFG_CAPTURE_BIAS, pick_value(24));
    write_reg(CFG_WRAP_THRESHOLD, pick_value(24));
    write_reg(CFG_WRAP_ADD, pick_value(24));
    write_reg(CFG_REF_CLK, pick_value(32));
    write_reg(CFG_RF_HZ, pick_value(32));
  endtask

  task test_stopped_estimator;
    send_sample(MAX_COUNT, 24'hFFFFFF);
    send_sample(8'd0, 24'h000000);
    send_sample(END_COUNT_RESET, 24'h5A5A5A);
    wait_idle();
  endtask

  task test_single_pulse_window;
    write_reg(CFG_SECONDS, 32'd1);
    write_reg(CFG_MODE, 32'd0);
    write_reg(CFG_CAPTURE_BIAS, 32'h100);
    write_reg(CFG_WRAP_THRESHOLD, 32'h200);
    write_reg(CFG_WRAP_ADD, 32'hFFFFFF);
    write_reg(CFG_REF_CLK, 32'd10_000_000);
    write_reg(CFG_RF_HZ, 32'hFFFF_FFFF);
    send_sample(END_COUNT_RESET, 24'h123456);
    send_sample(8'd0, 24'h0001FF);
    send_sample(END_COUNT_RESET, 24'h000000);
    send_sample(8'd0, 24'hFFFFFF);
    wait_idle();
  endtask

  task test_event_kinds;
    write_reg(CFG_SECONDS, 32'd2);
    send_sample(END_COUNT_RESET, 24'h000010);
    send_sample(END_COUNT_RESET, 24'h000020);
    send_sample(8'd0, 24'h000300);
    send_sample(MAX_COUNT, 24'h000400);
    send_sample(8'd0, 24'h000500);
    send_sample(8'd1, 24'h000600);
    send_sample(8'd0, 24'h000700);
    send_sample(8'd4, 24'h000800);
    send_sample(8'd9, 24'h000900);
    send_sample(8'd2, 24'h000A00);
    send_sample(8'd1, 24'h000B00);
    wait_idle();
  endtask

  task test_zero_divisor;
    write_reg(CFG_SECONDS, 32'd1);
    write_reg(CFG_REF_CLK, 32'd0);
    write_reg(CFG_CAPTURE_BIAS, 32'h10);
    write_reg(CFG_WRAP_THRESHOLD, 32'd0);
    send_sample(END_COUNT_RESET, 24'hABCDEF);
    send_sample(8'd0, 24'h00000F);
    wait_idle();
  endtask

  task test_wide_quotient;
    write_reg(CFG_REF_CLK, 32'hFFFFFF);
    write_reg(CFG_CAPTURE_BIAS, 32'hFFFFFF);
    send_sample(END_COUNT_RESET, 24'h800000);
    send_sample(8'd0, 24'h000000);
    wait_idle();
  endtask

  task test_shortened_window;
    write_reg(CFG_END_COUNT, 32'd20);
    write_reg(CFG_WRAP_THRESHOLD, 32'hFFFFFF);
    write_reg(CFG_MODE, 32'd1);
    write_reg(CFG_SECONDS, 32'd2);
    write_reg(CFG_REF_CLK, 32'd50_000_000);
    write_reg(CFG_RF_HZ, 32'd1_575_420_000);
    send_sample(END_COUNT_MULTI, 24'h3C0000);
    send_sample(8'd0, 24'h012345);
    wait_idle();
    write_reg(CFG_MODE, 32'd0);
    write_reg(CFG_SECONDS, 32'd1);
    send_sample(8'd20, 24'h777777);
    send_sample(8'd0, 24'h000321);
    wait_idle();
  endtask

  task test_random_traffic;
    int start;
    int need;
    logic [7:0] secs;
    start = live_items;
    no_idle = 1'b0;
    randomize_registers(8'd255, 1'b0);
    repeat (255) send_pulse();
    wait_idle();
    while (live_items - start < RANDOM_ITEMS) begin
      no_idle = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0: secs = 8'd0;
        1: secs = 8'($urandom_range(4, 12));
        default: secs = 8'($urandom_range(1, 3));
      endcase
      randomize_registers(secs, secs > 8'd3 ? 1'b0 : 1'($urandom_range(0, 1)));
      need = pps_mode ? int'(win_seconds) * PPS_DEFAULT : int'(win_seconds);
      if (need == 0) begin
        repeat (6) send_noise();
      end else begin
        repeat ($urandom_range(1, 3) * need) begin
          if ($urandom_range(0, 9) == 0) send_noise();
          send_pulse();
        end
      end
      wait_idle();
    end
    no_idle = 1'b0;
  endtask

  always @(posedge clk) begin : check_results
    logic signed [DEV_W-1:0] want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_deviation.size() == 0) begin
        report_mismatch($sformatf("unexpected deviation %0d", out_deviation));
      end else begin
        want = expected_deviation.pop_front();
        if (out_deviation !== want)
          report_mismatch($sformatf("deviation %0d, expected %0d", out_deviation, want));
      end
      stall_left = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
    end
  end

  always @(negedge clk) begin
    if (out_valid && stall_left > 0) stall_left--;
    out_ready <= (stall_left == 0);
  end

  initial begin
    #RUN_LIMIT;
    $display("FAIL");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_timer_count = '0;
    in_capture_value = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_SECONDS;
    cfg_wdata = '0;
    error_count = 0;
    live_items = 0;
    stall_left = 0;
    no_idle = 1'b0;
    win_seconds = 8'd0;
    pps_mode = 1'b0;
    end_mark = END_COUNT_RESET;
    cap_bias = 24'd0;
    wrap_thr = 24'd0;
    wrap_add_v = 24'd0;
    ref_ticks = 32'd0;
    rf_freq = 32'd0;
    last_count = 8'd0;
    last_valid = 1'b0;
    pulses_seen = 0;
    offset_acc = 0;
    repeat (5) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    test_stopped_estimator();
    test_single_pulse_window();
    test_event_kinds();
    test_zero_divisor();
    test_wide_quotient();
    test_shortened_window();
    test_random_traffic();
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== pps_frequency_deviation_estimator_top.f =====
rtl/core/ppsfde_pkg.sv
rtl/core/ppsfde_engine.sv
rtl/core/pps_frequency_deviation_estimator_top.sv
rtl/core/ppsfde_checker.sv
sim/testbench.sv
